[rtl/core/multi_finger_swipe_tap_detector_macros.svh]
// Assertion macros shared by the checker files of the detector.
`ifndef MULTI_FINGER_SWIPE_TAP_DETECTOR_MACROS_SVH
`define MULTI_FINGER_SWIPE_TAP_DETECTOR_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MFST_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfst check failed");

// Next-cycle implication, off while reset is high.
`define MFST_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfst check failed");

// Next-cycle implication that also holds through reset.
`define MFST_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mfst check failed");

`endif

[rtl/core/mfst_pkg.sv]
// ----------------------------------------------------------------------------
// mfst_pkg
// Types, codes and constants of the multi-finger swipe and tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mfst_pkg;

  localparam int MAX_FINGERS   = 5;
  localparam int NBANK         = MAX_FINGERS - 1;
  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_W         = 21;
  localparam int DIV_STEPS     = DIV_W;

  localparam logic [15:0] MIN_DISTANCE_RST = 16'd3277;
  localparam logic [14:0] MIN_VELOCITY_RST = 15'd102;
  localparam logic [9:0]  AXIS_RATIO_RST   = 10'd371;
  localparam logic [23:0] TAP_DURATION_RST = 24'd180000;
  localparam logic [15:0] TAP_MOVEMENT_RST = 16'd2621;

  // Offset that keeps the signed velocity sum positive through the divider.
  localparam logic [DIV_W-1:0] VEL_BIAS = DIV_W'(262144);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DISTANCE = 3'd0,
    CFG_MIN_VELOCITY = 3'd1,
    CFG_AXIS_RATIO   = 3'd2,
    CFG_TAP_DURATION = 3'd3,
    CFG_TAP_MOVEMENT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_LEFT  = 3'd0,
    KIND_RIGHT = 3'd1,
    KIND_DOWN  = 3'd2,
    KIND_UP    = 3'd3,
    KIND_TAP   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_DELTA,
    S_MULT,
    S_SWIPE,
    S_LIFT,
    S_LIFT_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]         finger_count;
    logic               finger_active;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [31:0]        timestamp_us;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [2:0] gesture_fingers;
    logic [2:0] gesture_kind;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic accum;
    logic capture;
    logic decide;
    logic clr_bank0;
    logic div_step;
    logic delta;
    logic mult;
    logic swipe_commit;
    logic lift_step;
    logic lift_commit;
  } cmd_t;

  typedef struct packed {
    logic is_lift;
    logic frame_ok;
    logic cnt_is_two;
    logic div_done;
    logic bank_tracking;
    logic bank_fired;
    logic swipe_hit;
    logic lift_last;
    logic pend_empty;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/mfst_dp.sv]
// ----------------------------------------------------------------------------
// mfst_dp
// Datapath: frame sums, shared divider, tracking banks, swipe and tap tests,
// and the pending result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfst_dp #(
  parameter int TIME_BITS = mfst_pkg::TIME_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  mfst_pkg::cmd_t                       cmd,
  output mfst_pkg::status_t                    sts,
  input  mfst_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output mfst_pkg::out_item_t                  out_data,
  input  wire                                  cfg_we,
  input  wire [mfst_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire [mfst_pkg::CFG_W-1:0]            cfg_data
);
  import mfst_pkg::*;

  // configuration
  logic [15:0] min_dist;
  logic [14:0] min_vel;
  logic [9:0]  ratio;
  logic [23:0] tap_dur;
  logic [15:0] tap_mov;

  // frame accumulation
  logic [18:0]        sum_px, sum_py;
  logic signed [18:0] sum_vx, sum_vy;
  logic [2:0]         seen;
  logic [3:0]         cnt_q;
  logic [TIME_BITS-1:0] ts_q;

  // divider
  logic [DIV_W-1:0] dvd [4];
  logic [2:0]       rem [4];
  logic [4:0]       div_cnt;
  logic [2:0]       div_n;
  logic [DIV_W-1:0] bias_n;

  // banks
  logic [NBANK-1:0]     trk, fired;
  logic [15:0]          sx  [NBANK];
  logic [15:0]          sy  [NBANK];
  logic [TIME_BITS-1:0] st  [NBANK];
  logic [15:0]          exc [NBANK];
  logic [1:0]           bank_sel, lift_idx;
  logic [NBANK-1:0]     tap_mask;

  // delta and product stages
  logic               d_negx, d_negy, v_negx, v_negy;
  logic [15:0]        adx_q, ady_q, avx_q, avy_q;
  logic [25:0]        p_adx, p_ady, p_avx, p_avy;

  // pending results
  logic [NBANK-1:0] pend_mask;
  logic [2:0]       pend_kind;

  // combinational
  logic [15:0]        avg_x, avg_y;
  logic signed [15:0] avg_vx, avg_vy;
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady, avx, avy, exc_new;
  logic               x_dom, y_dom, vx_dom, vy_dom;
  logic               dist_x, dist_y, vel_x_ok, vel_y_ok;
  logic               go_left, go_right, go_down, go_up;
  logic [2:0]         swipe_kind;
  logic [TIME_BITS-1:0] dur;
  logic               tap_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DISTANCE_RST;
      min_vel  <= MIN_VELOCITY_RST;
      ratio    <= AXIS_RATIO_RST;
      tap_dur  <= TAP_DURATION_RST;
      tap_mov  <= TAP_MOVEMENT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_DISTANCE: min_dist <= cfg_data[15:0];
        CFG_MIN_VELOCITY: min_vel  <= cfg_data[14:0];
        CFG_AXIS_RATIO:   ratio    <= cfg_data[9:0];
        CFG_TAP_DURATION: tap_dur  <= cfg_data[23:0];
        CFG_TAP_MOVEMENT: tap_mov  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_px <= '0;
      sum_py <= '0;
      sum_vx <= '0;
      sum_vy <= '0;
      seen   <= '0;
    end else if (cmd.decide) begin
      sum_px <= '0;
      sum_py <= '0;
      sum_vx <= '0;
      sum_vy <= '0;
      seen   <= '0;
    end else if (cmd.accum && in_data.finger_active && seen != 3'd7) begin
      sum_px <= sum_px + 19'(in_data.pos_x);
      sum_py <= sum_py + 19'(in_data.pos_y);
      sum_vx <= sum_vx + 19'(in_data.vel_x);
      sum_vy <= sum_vy + 19'(in_data.vel_y);
      seen   <= seen + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_q <= in_data.finger_count;
      ts_q  <= TIME_BITS'(in_data.timestamp_us);
    end
  end

  assign div_n  = cnt_q[2:0];
  assign bias_n = {div_n, 18'd0};

  // One quotient bit per cycle for all four sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.decide) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    logic [3:0] rsh;
    logic       ge;
    if (cmd.decide) begin
      dvd[0] <= DIV_W'(sum_px);
      dvd[1] <= DIV_W'(sum_py);
      dvd[2] <= DIV_W'(sum_vx) + bias_n;
      dvd[3] <= DIV_W'(sum_vy) + bias_n;
      for (int i = 0; i < 4; i++) rem[i] <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 4; i++) begin
        rsh    = {rem[i], dvd[i][DIV_W-1]};
        ge     = rsh >= {1'b0, div_n};
        rem[i] <= ge ? 3'(rsh - {1'b0, div_n}) : rsh[2:0];
        dvd[i] <= {dvd[i][DIV_W-2:0], ge};
      end
    end
  end

  assign avg_x  = dvd[0][15:0];
  assign avg_y  = dvd[1][15:0];
  assign avg_vx = signed'(16'(dvd[2] - VEL_BIAS));
  assign avg_vy = signed'(16'(dvd[3] - VEL_BIAS));

  assign bank_sel = cmd.lift_step ? lift_idx : 2'(cnt_q[1:0] - 2'd2);

  always_comb begin
    dx  = signed'({1'b0, avg_x}) - signed'({1'b0, sx[bank_sel]});
    dy  = signed'({1'b0, avg_y}) - signed'({1'b0, sy[bank_sel]});
    adx = dx[16] ? 16'(-dx) : dx[15:0];
    ady = dy[16] ? 16'(-dy) : dy[15:0];
    avx = avg_vx[15] ? 16'(-avg_vx) : avg_vx;
    avy = avg_vy[15] ? 16'(-avg_vy) : avg_vy;
    exc_new = exc[bank_sel];
    if (adx > exc_new) exc_new = adx;
    if (ady > exc_new) exc_new = ady;
  end

  always_ff @(posedge clk) begin
    if (cmd.delta && trk[bank_sel] && !fired[bank_sel]) begin
      d_negx <= dx[16];
      d_negy <= dy[16];
      v_negx <= avg_vx[15];
      v_negy <= avg_vy[15];
      adx_q  <= adx;
      ady_q  <= ady;
      avx_q  <= avx;
      avy_q  <= avy;
    end
    if (cmd.mult) begin
      p_adx <= adx_q * ratio;
      p_ady <= ady_q * ratio;
      p_avx <= avx_q * ratio;
      p_avy <= avy_q * ratio;
    end
  end

  always_comb begin
    x_dom    = {2'b0, adx_q, 8'd0} > p_ady;
    y_dom    = {2'b0, ady_q, 8'd0} > p_adx;
    vx_dom   = {2'b0, avx_q, 8'd0} > p_avy;
    vy_dom   = {2'b0, avy_q, 8'd0} > p_avx;
    dist_x   = adx_q > min_dist;
    dist_y   = ady_q > min_dist;
    vel_x_ok = avx_q > {1'b0, min_vel};
    vel_y_ok = avy_q > {1'b0, min_vel};
    go_left  = d_negx && dist_x && x_dom && v_negx && vel_x_ok && vx_dom;
    go_right = !d_negx && dist_x && x_dom && !v_negx && vel_x_ok && vx_dom;
    go_down  = d_negy && dist_y && y_dom && v_negy && vel_y_ok && vy_dom;
    go_up    = !d_negy && dist_y && y_dom && !v_negy && vel_y_ok && vy_dom;
    if (go_left)       swipe_kind = KIND_LEFT;
    else if (go_right) swipe_kind = KIND_RIGHT;
    else if (go_down)  swipe_kind = KIND_DOWN;
    else               swipe_kind = KIND_UP;
  end

  assign dur     = ts_q - st[lift_idx];
  assign tap_bit = trk[lift_idx] && !fired[lift_idx] &&
                   dur <= TIME_BITS'(tap_dur) && exc[lift_idx] <= tap_mov;

  always_ff @(posedge clk) begin
    if (rst) begin
      trk   <= '0;
      fired <= '0;
    end else if (cmd.lift_commit) begin
      trk   <= '0;
      fired <= '0;
    end else if (cmd.clr_bank0) begin
      trk[0]   <= 1'b0;
      fired[0] <= 1'b0;
    end else if (cmd.delta && !trk[bank_sel]) begin
      trk[bank_sel]   <= 1'b1;
      fired[bank_sel] <= 1'b0;
    end else if (cmd.swipe_commit) begin
      fired[bank_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      if (!trk[bank_sel]) begin
        sx[bank_sel]  <= avg_x;
        sy[bank_sel]  <= avg_y;
        st[bank_sel]  <= ts_q;
        exc[bank_sel] <= '0;
      end else if (!fired[bank_sel]) begin
        exc[bank_sel] <= exc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lift_idx <= '0;
      tap_mask <= '0;
    end else if (cmd.decide) begin
      lift_idx <= '0;
      tap_mask <= '0;
    end else if (cmd.lift_step) begin
      tap_mask[lift_idx] <= tap_bit;
      lift_idx           <= lift_idx + 2'd1;
    end
  end

  // Results leave lowest bank first; accept clears the lowest pending bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (cmd.swipe_commit) begin
      pend_mask <= NBANK'(1) << bank_sel;
    end else if (cmd.lift_commit) begin
      pend_mask <= tap_mask;
    end else if (out_valid && out_ready) begin
      pend_mask <= pend_mask & (pend_mask - NBANK'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.swipe_commit) begin
      pend_kind <= swipe_kind;
    end else if (cmd.lift_commit) begin
      pend_kind <= KIND_TAP;
    end
  end

  always_comb begin
    out_valid = |pend_mask;
    if (pend_mask[0])      out_data.gesture_fingers = 3'd2;
    else if (pend_mask[1]) out_data.gesture_fingers = 3'd3;
    else if (pend_mask[2]) out_data.gesture_fingers = 3'd4;
    else                   out_data.gesture_fingers = 3'd5;
    out_data.gesture_kind = pend_kind;
    out_data.last_result  = (pend_mask & (pend_mask - NBANK'(1))) == '0;
  end

  always_comb begin
    sts.is_lift       = cnt_q < 4'd2 || cnt_q > 4'(MAX_FINGERS);
    sts.frame_ok      = {1'b0, seen} == cnt_q;
    sts.cnt_is_two    = cnt_q == 4'd2;
    sts.div_done      = div_cnt == 5'(DIV_STEPS);
    sts.bank_tracking = trk[bank_sel];
    sts.bank_fired    = fired[bank_sel];
    sts.swipe_hit     = go_left || go_right || go_down || go_up;
    sts.lift_last     = lift_idx == 2'd3;
    sts.pend_empty    = ~|pend_mask;
  end

endmodule

`default_nettype wire

[rtl/core/mfst_ctrl.sv]
// ----------------------------------------------------------------------------
// mfst_ctrl
// Controller: sequences frame decision, division, swipe test and lift scan.
// ----------------------------------------------------------------------------
`default_nettype none

module mfst_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_last,
  output logic               in_ready,
  input  mfst_pkg::status_t  sts,
  output mfst_pkg::cmd_t     cmd
);
  import mfst_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept && in_last) state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.is_lift)       state_next = S_LIFT;
        else if (sts.frame_ok) state_next = S_DIV;
        else                   state_next = S_IDLE;
      end
      S_DIV:      if (sts.div_done) state_next = S_DELTA;
      S_DELTA: begin
        if (sts.bank_tracking && !sts.bank_fired) state_next = S_MULT;
        else                                      state_next = S_IDLE;
      end
      S_MULT:     state_next = S_SWIPE;
      // hold a hit until the result register is free
      S_SWIPE:    if (!sts.swipe_hit || sts.pend_empty) state_next = S_IDLE;
      S_LIFT:     if (sts.lift_last) state_next = S_LIFT_OUT;
      S_LIFT_OUT: if (sts.pend_empty) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.accum   = accept;
        cmd.capture = accept && in_last;
      end
      S_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.clr_bank0 = !sts.is_lift && sts.frame_ok && !sts.cnt_is_two;
      end
      S_DIV:      cmd.div_step = !sts.div_done;
      S_DELTA:    cmd.delta = 1'b1;
      S_MULT:     cmd.mult = 1'b1;
      S_SWIPE:    cmd.swipe_commit = sts.swipe_hit && sts.pend_empty;
      S_LIFT:     cmd.lift_step = 1'b1;
      S_LIFT_OUT: cmd.lift_commit = sts.pend_empty;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/multi_finger_swipe_tap_detector.sv]
// ----------------------------------------------------------------------------
// multi_finger_swipe_tap_detector
// Swipe and tap recognition over touch frames of two to five fingers.
// ----------------------------------------------------------------------------
// A finger record that does not close its frame is taken and the input stays
// ready. The closing record of a frame with 2 to 5 fingers goes through a
// decide step, the bit-serial divider that averages the four sums (21 quotient
// steps), then delta, multiply and swipe-test steps; a frame that only starts
// tracking skips the last two. A lift scans the banks one after another for taps.
// Results sit in an output register and leave one per cycle as they are taken;
// input records are still accepted meanwhile, and a frame that produces
// results waits only if earlier results are still unread.
`default_nettype none

module multi_finger_swipe_tap_detector #(
  parameter int TIME_BITS = mfst_pkg::TIME_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  mfst_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output mfst_pkg::out_item_t            out_data,
  input  wire                            cfg_we,
  input  wire [mfst_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire [mfst_pkg::CFG_W-1:0]      cfg_data
);
  import mfst_pkg::*;

  cmd_t    cmd;
  status_t sts;

  mfst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_in_frame),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfst_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

[rtl/core/mfst_checker.sv]
// ----------------------------------------------------------------------------
// mfst_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_finger_swipe_tap_detector_macros.svh"

module mfst_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  out_valid,
  input wire                  out_ready,
  input mfst_pkg::out_item_t  out_data
);
  import mfst_pkg::*;

  logic fingers_ok;
  logic kind_ok;

  assign fingers_ok = out_data.gesture_fingers inside {[3'd2:3'd5]};
  assign kind_ok    = out_data.gesture_kind inside {KIND_LEFT, KIND_RIGHT, KIND_DOWN,
                                                    KIND_UP, KIND_TAP};

  `MFST_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)
  `MFST_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `MFST_ASSERT_IMPL(a_fingers_range, clk, rst, out_valid, fingers_ok)
  `MFST_ASSERT_IMPL(a_kind_range, clk, rst, out_valid, kind_ok)
  `MFST_ASSERT_IMPL(a_swipe_single, clk, rst, out_valid && !out_data.gesture_kind[2], out_data.last_result)

endmodule

bind multi_finger_swipe_tap_detector mfst_checker u_mfst_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives touch frames into the swipe and tap detector and checks every
// gesture against a cycle-free predictor of the frame averaging, swipe tests
// and lift taps, across several threshold settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mfst_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  multi_finger_swipe_tap_detector u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // thresholds as the block holds them
  int unsigned thr_dist, thr_vel, thr_ratio, thr_tap_dur, thr_tap_move;

  // tracking banks, bank b holds finger count b+2
  bit          trk [NBANK];
  bit          fired [NBANK];
  int          org_x [NBANK];
  int          org_y [NBANK];
  logic [31:0] org_t [NBANK];
  int          excur [NBANK];
  int          acc_px, acc_py, acc_vx, acc_vy, acc_seen;

  in_item_t  rec_q[$];
  out_item_t gesture_q[$];

  int unsigned tx_idle = 0, rx_idle = 0;
  bit          in_took = 0;
  bit          hold_req = 0;
  int          hold_cnt = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  logic [31:0] now_us = 32'd1000;

  task automatic clear_banks();
    for (int b = 0; b < NBANK; b++) begin
      trk[b] = 0; fired[b] = 0; excur[b] = 0;
    end
  endtask

  task automatic predict_gestures(in_item_t r);
    out_item_t   found[$];
    out_item_t   g;
    int          cnt, b, ax, ay, vx, vy, dx, dy, adx, ady, avx, avy, md, mv, rt;
    int          px, py, pvx, pvy, seen;
    bit          hit;
    kind_t       kind;
    logic [31:0] dur;
    if (r.finger_active && acc_seen < 7) begin
      acc_px += r.pos_x;
      acc_py += r.pos_y;
      acc_vx += int'(r.vel_x);
      acc_vy += int'(r.vel_y);
      acc_seen++;
    end
    if (!r.last_in_frame) return;
    px = acc_px; py = acc_py; pvx = acc_vx; pvy = acc_vy; seen = acc_seen;
    acc_px = 0; acc_py = 0; acc_vx = 0; acc_vy = 0; acc_seen = 0;
    cnt = r.finger_count;
    if (cnt < 2 || cnt > MAX_FINGERS) begin
      for (b = 0; b < NBANK; b++) begin
        dur = r.timestamp_us - org_t[b];
        if (trk[b] && !fired[b] && dur <= thr_tap_dur && excur[b] <= thr_tap_move) begin
          g.gesture_fingers = 3'(b + 2);
          g.gesture_kind = KIND_TAP;
          g.last_result = 1'b0;
          found.push_back(g);
        end
      end
      clear_banks();
    end else if (seen == cnt) begin
      if (cnt != 2) begin
        trk[0] = 0; fired[0] = 0;
      end
      b = cnt - 2;
      ax = px / cnt;
      ay = py / cnt;
      vx = (pvx + cnt * 262144) / cnt - 262144;
      vy = (pvy + cnt * 262144) / cnt - 262144;
      if (!trk[b]) begin
        trk[b] = 1; fired[b] = 0;
        org_x[b] = ax; org_y[b] = ay; org_t[b] = r.timestamp_us; excur[b] = 0;
      end else if (!fired[b]) begin
        dx = ax - org_x[b];
        dy = ay - org_y[b];
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx > excur[b]) excur[b] = adx;
        if (ady > excur[b]) excur[b] = ady;
        avx = vx < 0 ? -vx : vx;
        avy = vy < 0 ? -vy : vy;
        md = thr_dist; mv = thr_vel; rt = thr_ratio;
        hit = 1;
        if (dx < -md && adx * 256 > ady * rt && vx < -mv && avx * 256 > avy * rt)
          kind = KIND_LEFT;
        else if (dx > md && adx * 256 > ady * rt && vx > mv && avx * 256 > avy * rt)
          kind = KIND_RIGHT;
        else if (dy < -md && ady * 256 > adx * rt && vy < -mv && avy * 256 > avx * rt)
          kind = KIND_DOWN;
        else if (dy > md && ady * 256 > adx * rt && vy > mv && avy * 256 > avx * rt)
          kind = KIND_UP;
        else
          hit = 0;
        if (hit) begin
          fired[b] = 1;
          g.gesture_fingers = 3'(b + 2);
          g.gesture_kind = kind;
          g.last_result = 1'b0;
          found.push_back(g);
        end
      end
    end
    if (found.size() > 0) found[found.size() - 1].last_result = 1'b1;
    foreach (found[i]) gesture_q.push_back(found[i]);
  endtask

  // input side: predict on each accepted transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_gestures(in_data);
      in_took = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (!rst && rec_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_data <= rec_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_took = 0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (gesture_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected gesture: fingers %0d kind %0d last %0d",
                   out_data.gesture_fingers, out_data.gesture_kind, out_data.last_result);
      end else begin
        want = gesture_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("gesture mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.gesture_fingers, want.gesture_kind, want.last_result,
                     out_data.gesture_fingers, out_data.gesture_kind, out_data.last_result);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      CFG_MIN_DISTANCE: thr_dist = val & 32'hFFFF;
      CFG_MIN_VELOCITY: thr_vel = val & 32'h7FFF;
      CFG_AXIS_RATIO:   thr_ratio = val & 32'h3FF;
      CFG_TAP_DURATION: thr_tap_dur = val & 32'hFFFFFF;
      CFG_TAP_MOVEMENT: thr_tap_move = val & 32'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(int unsigned d, int unsigned v, int unsigned r,
                                int unsigned t, int unsigned m);
    write_reg(CFG_MIN_DISTANCE, d);
    write_reg(CFG_MIN_VELOCITY, v);
    write_reg(CFG_AXIS_RATIO, r);
    write_reg(CFG_TAP_DURATION, t);
    write_reg(CFG_TAP_MOVEMENT, m);
  endtask

  function automatic logic [15:0] clamp_u16(int v);
    return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : 16'(v));
  endfunction

  function automatic logic [15:0] clamp_s16(int v);
    return v < -32768 ? 16'h8000 : (v > 32767 ? 16'h7FFF : 16'(v));
  endfunction

  task automatic push_rec(int cnt, bit act, int x, int y, int vx, int vy,
                          logic [31:0] ts, bit last);
    in_item_t r;
    r.finger_count = 4'(cnt);
    r.finger_active = act;
    r.pos_x = clamp_u16(x);
    r.pos_y = clamp_u16(y);
    r.vel_x = clamp_s16(vx);
    r.vel_y = clamp_s16(vy);
    r.timestamp_us = ts;
    r.last_in_frame = last;
    rec_q.push_back(r);
  endtask

  // one frame of n fingers around a center; drop makes one finger inactive
  task automatic send_frame(int n, int cx, int cy, int vx, int vy, bit drop, int jit);
    int off;
    off = drop ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++)
      push_rec(n, i != off, cx + $urandom_range(0, 2 * jit) - jit,
               cy + $urandom_range(0, 2 * jit) - jit,
               vx + $urandom_range(0, 2 * jit) - jit,
               vy + $urandom_range(0, 2 * jit) - jit, now_us, i == n - 1);
  endtask

  function automatic int lift_count();
    int v;
    v = $urandom_range(0, 11);
    return v < 2 ? v : v + 4;
  endfunction

  task automatic send_lift(int recs);
    int c;
    c = lift_count();
    now_us += $urandom_range(2000, 30000);
    for (int i = 0; i < recs; i++)
      push_rec(c, $urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
               now_us, i == recs - 1);
  endtask

  // start frame, a few moving frames, usually a lift
  task automatic random_gesture();
    int n, dir, frames, cx, cy, stride, vmag, vx, vy, sx, sy;
    n = $urandom_range(2, 5);
    dir = $urandom_range(0, 5);
    frames = $urandom_range(2, 5);
    cx = $urandom_range(12000, 53000);
    cy = $urandom_range(12000, 53000);
    stride = dir == 4 ? $urandom_range(0, 600) : $urandom_range(800, 6000);
    if ($urandom_range(0, 15) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 40000);
    for (int f = 0; f < frames; f++) begin
      sx = (dir == 0) ? -1 : (dir == 1) ? 1 : 0;
      sy = (dir == 2) ? -1 : (dir == 3) ? 1 : 0;
      if (dir == 5) begin
        sx = $urandom_range(0, 2) - 1;
        sy = $urandom_range(0, 2) - 1;
      end
      if (f > 0) begin
        cx += sx * stride;
        cy += sy * stride;
      end
      vmag = $urandom_range(40, 6000);
      vx = sx * vmag + $urandom_range(0, 400) - 200;
      vy = sy * vmag + $urandom_range(0, 400) - 200;
      if (dir == 4) begin
        vx = $urandom_range(0, 200) - 100;
        vy = $urandom_range(0, 200) - 100;
      end
      now_us += $urandom_range(4000, 45000);
      send_frame(n, cx, cy, vx, vy, $urandom_range(0, 11) == 0, 300);
    end
    if ($urandom_range(0, 9) < 7) send_lift($urandom_range(1, 3));
  endtask

  task automatic noise_rec();
    in_item_t r;
    r.finger_count  = 4'($urandom);
    r.finger_active = 1'($urandom);
    r.pos_x         = 16'($urandom);
    r.pos_y         = 16'($urandom);
    r.vel_x         = 16'($urandom);
    r.vel_y         = 16'($urandom);
    r.timestamp_us  = $urandom;
    r.last_in_frame = 1'($urandom);
    rec_q.push_back(r);
  endtask

  task automatic directed_frames();
    // more than seven records in one frame: dropped
    for (int i = 0; i < 8; i++) push_rec(5, 1, 30000, 30000, 0, 0, now_us, i == 7);
    // extremes of position and velocity
    push_rec(2, 1, 0, 0, -32768, -32768, now_us, 0);
    push_rec(2, 1, 65535, 65535, 32767, 32767, now_us, 1);
    now_us += 10000;
    push_rec(2, 1, 0, 0, -32768, -32768, now_us, 0);
    push_rec(2, 1, 0, 0, -32768, 0, now_us, 1);
    send_lift(1);
    // banks for three, four, five, then two: lift reports four taps
    now_us += 10000;
    send_frame(3, 20000, 20000, 0, 0, 0, 0);
    send_frame(4, 30000, 30000, 0, 0, 0, 0);
    send_frame(5, 40000, 40000, 0, 0, 0, 0);
    send_frame(2, 50000, 50000, 0, 0, 0, 0);
    now_us += 20000;
    push_rec(0, 0, 0, 0, 0, 0, now_us, 1);
    // one swipe of each direction with its own finger count
    send_frame(2, 40000, 30000, 0, 0, 0, 0);
    now_us += 20000;
    send_frame(2, 30000, 30000, -3000, 0, 0, 0);
    send_frame(3, 20000, 30000, 0, 0, 0, 0);
    now_us += 20000;
    send_frame(3, 30000, 30000, 3000, 0, 0, 0);
    send_frame(4, 30000, 40000, 0, 0, 0, 0);
    now_us += 20000;
    send_frame(4, 30000, 30000, 0, -3000, 0, 0);
    send_frame(5, 30000, 20000, 0, 0, 1, 0);
    send_frame(5, 30000, 20000, 0, 0, 0, 0);
    now_us += 20000;
    send_frame(5, 30000, 30000, 0, 3000, 0, 0);
    push_rec(15, 1, 0, 0, 0, 0, now_us, 1);
  endtask

  task automatic drain();
    while (rec_q.size() > 0 || in_valid || gesture_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int sent;
    thr_dist = MIN_DISTANCE_RST;
    thr_vel = MIN_VELOCITY_RST;
    thr_ratio = AXIS_RATIO_RST;
    thr_tap_dur = TAP_DURATION_RST;
    thr_tap_move = TAP_MOVEMENT_RST;
    clear_banks();
    acc_px = 0; acc_py = 0; acc_vx = 0; acc_vy = 0; acc_seen = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_thresholds(3277, 102, 371, 180000, 2621); tx_idle = 0;  rx_idle = 0;  end
        1: begin set_thresholds(0, 0, 0, 0, 0);                tx_idle = 53; rx_idle = 0;  end
        2: begin set_thresholds(65535, 32767, 1023, 16777215, 65535);
                 tx_idle = 0;  rx_idle = 53; end
        3: begin set_thresholds($urandom_range(0, 8000), $urandom_range(0, 400),
                                $urandom_range(0, 1023), $urandom_range(0, 300000),
                                $urandom_range(0, 6000));
                 tx_idle = 26; rx_idle = 26; end
        4: begin set_thresholds(3277, 102, 371, 180000, 2621); tx_idle = 0;  rx_idle = 0;
                 hold_req = 1; end
        default: begin set_thresholds(1000, 50, 256, 60000, 4000);
                       tx_idle = 26; rx_idle = 26; end
      endcase
      if (ph == 0) directed_frames();
      sent = rec_q.size();
      while (rec_q.size() - sent < 70) begin
        if ($urandom_range(0, 9) == 0) noise_rec();
        else random_gesture();
      end
      drain();
    end
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
